// ===== rtl/des_pkg.sv =====
// DES package: tables, action codes, permutation and round functions.
`timescale 1ns / 1ps
package des_pkg;

   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_ENCRYPT = 2'd1,
      ACT_DECRYPT = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   localparam int KeyWidth   = 48;
   localparam int BlockWidth = 64;
   localparam int HalfWidth  = 32;
   localparam int KeyDepth   = 16;

   typedef logic [7:0] tab64_type [64];
   typedef logic [7:0] tab48_type [48];
   typedef logic [7:0] tab32_type [32];
   typedef logic [3:0] sbox_type [8][64];

   localparam tab64_type IP_TAB = '{
      8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,8'd10,8'd2, 8'd60,8'd52,8'd44,8'd36,8'd28,8'd20,8'd12,8'd4,
      8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,8'd14,8'd6, 8'd64,8'd56,8'd48,8'd40,8'd32,8'd24,8'd16,8'd8,
      8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,  8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,
      8'd61,8'd53,8'd45,8'd37,8'd29,8'd21,8'd13,8'd5, 8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7};

   localparam tab64_type FP_TAB = '{
      8'd40,8'd8,8'd48,8'd16,8'd56,8'd24,8'd64,8'd32, 8'd39,8'd7,8'd47,8'd15,8'd55,8'd23,8'd63,8'd31,
      8'd38,8'd6,8'd46,8'd14,8'd54,8'd22,8'd62,8'd30, 8'd37,8'd5,8'd45,8'd13,8'd53,8'd21,8'd61,8'd29,
      8'd36,8'd4,8'd44,8'd12,8'd52,8'd20,8'd60,8'd28, 8'd35,8'd3,8'd43,8'd11,8'd51,8'd19,8'd59,8'd27,
      8'd34,8'd2,8'd42,8'd10,8'd50,8'd18,8'd58,8'd26, 8'd33,8'd1,8'd41,8'd9,8'd49,8'd17,8'd57,8'd25};

   localparam tab48_type E_TAB = '{
      8'd32,8'd1,8'd2,8'd3,8'd4,8'd5, 8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,
      8'd8,8'd9,8'd10,8'd11,8'd12,8'd13, 8'd12,8'd13,8'd14,8'd15,8'd16,8'd17,
      8'd16,8'd17,8'd18,8'd19,8'd20,8'd21, 8'd20,8'd21,8'd22,8'd23,8'd24,8'd25,
      8'd24,8'd25,8'd26,8'd27,8'd28,8'd29, 8'd28,8'd29,8'd30,8'd31,8'd32,8'd1};

   localparam tab32_type P_TAB = '{
      8'd16,8'd7,8'd20,8'd21,8'd29,8'd12,8'd28,8'd17, 8'd1,8'd15,8'd23,8'd26,8'd5,8'd18,8'd31,8'd10,
      8'd2,8'd8,8'd24,8'd14,8'd32,8'd27,8'd3,8'd9, 8'd19,8'd13,8'd30,8'd6,8'd22,8'd11,8'd4,8'd25};

   // rows of 16 in order row0..row3, entry = row*16 + col
   localparam sbox_type SBOX = '{
      '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
        4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
        4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
        4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
      '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
        4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
        4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
        4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
      '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
        4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
        4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
        4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
      '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
        4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
        4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
        4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
      '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
        4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
        4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
        4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
      '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
        4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
        4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
        4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
      '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
        4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
        4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
        4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
      '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
        4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
        4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
        4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

   // table entry t (1..64) picks bit t counted from the MSB
   function automatic logic [63:0] perm64(input logic [63:0] v, input tab64_type tab);
      logic [63:0] o;
      o = '0;
      for (int i = 0; i < 64; i++) o[63-i] = v[6'(7'd64 - tab[i][6:0])];
      return o;
   endfunction

   // one Feistel round: returns {new_l, new_r}
   function automatic logic [63:0] feistel_stage(input logic [63:0] lr, input logic [47:0] k);
      logic [31:0] r;
      logic [47:0] x;
      logic [31:0] s;
      logic [31:0] p;
      logic [5:0]  six;
      r = lr[31:0];
      for (int i = 0; i < 48; i++) x[47-i] = r[5'(6'd32 - E_TAB[i][5:0])];
      x = x ^ k;
      for (int i = 0; i < 8; i++) begin
         six = x[47-6*i -: 6];
         s[31-4*i -: 4] = SBOX[i][{six[5], six[0], six[4:1]}];
      end
      for (int i = 0; i < 32; i++) p[31-i] = s[5'(6'd32 - P_TAB[i][5:0])];
      return {r, lr[63:32] ^ p};
   endfunction

endpackage

// ===== rtl/des_block_cipher_top.sv =====
// DES ECB cipher top level: key store plus sixteen-stage round pipeline.
//
//  channel | dir | fields
//  req_*   | in  | tdata: action[1:0] key_index[5:2] round_key_value[53:6] data_block[117:54]
//  rsp_*   | out | tdata: result_block[63:0]
//
// One beat per cycle in steady state while rsp is not stalled and no load beat waits; a block
// passes the input register with initial permutation, one stage per round, and the output stage.
// Load beats write the key store and travel as bubbles. Reset clears valid bits only.
// A stall at rsp freezes the whole pipeline; req_tready follows rsp_tready and free slots.
// A load beat waits until no block is left in the round stages, so blocks in flight
// keep the keys they entered with.
`timescale 1ns / 1ps
module des_block_cipher_top
   import des_pkg::*;
#(
   parameter int ROUND_COUNT = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [119:0] req_tdata,   // action, key_index, round_key_value, data_block
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata    // result_block
);

   localparam int Stages = ROUND_COUNT + 1;

   logic [1:0]  req_action;
   logic [3:0]  req_key_index;
   logic [47:0] req_key;
   logic [63:0] req_block;
   assign req_action    = req_tdata[1:0];
   assign req_key_index = req_tdata[5:2];
   assign req_key       = req_tdata[53:6];
   assign req_block     = req_tdata[117:54];

   // key store, all rounds read it at once -> flip-flops at fixed taps
   logic [47:0] key_ff [KeyDepth];

   // stage 0 holds IP output; stage s (1..ROUND_COUNT) holds after round s
   logic [63:0] lr_ff    [Stages];
   logic        vld_ff   [Stages];
   logic        dec_ff   [Stages];
   logic [63:0] out_ff;
   logic        out_vld_ff;
   logic        adv;
   logic        busy;

   // any block still in the round stages
   always_comb begin
      busy = 1'b0;
      for (int s = 0; s < Stages; s++) busy = busy | vld_ff[s];
   end

   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv && !(action_type'(req_action) == ACT_LOAD && busy);
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;

   logic req_fire, req_crypt;
   assign req_fire  = req_tvalid && req_tready;
   assign req_crypt = req_fire &&
      (action_type'(req_action) == ACT_ENCRYPT || action_type'(req_action) == ACT_DECRYPT);

   always_ff @(posedge clock) begin
      if (req_fire && action_type'(req_action) == ACT_LOAD) begin
         key_ff[req_key_index] <= req_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < Stages; s++) vld_ff[s] <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_crypt;
         for (int s = 1; s < Stages; s++) vld_ff[s] <= vld_ff[s-1];
         out_vld_ff <= vld_ff[Stages-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lr_ff[0]  <= perm64(req_block, IP_TAB);
         dec_ff[0] <= action_type'(req_action) == ACT_DECRYPT;
         for (int s = 1; s < Stages; s++) begin
            lr_ff[s]  <= feistel_stage(lr_ff[s-1], dec_ff[s-1] ?
                         key_ff[4'(ROUND_COUNT - s)] : key_ff[4'(s - 1)]);
            dec_ff[s] <= dec_ff[s-1];
         end
         out_ff <= perm64({lr_ff[Stages-1][31:0], lr_ff[Stages-1][63:32]}, FP_TAB);
      end
   end

   // output holds while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed under stall");
   // a crypt beat reaches the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_crypt |=> vld_ff[0])
      else $error("crypt beat lost");
   // pipeline frozen under stall: the last stage valid bit holds
   a_frz: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff[Stages-1]))
      else $error("pipeline moved under stall");
   // keys change only with no block in the rounds
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire && action_type'(req_action) == ACT_LOAD |-> !busy)
      else $error("key load with blocks in flight");

endmodule

// ===== verif/tb_des_block_cipher_top.sv =====
// Self-checking testbench for the DES ECB block cipher top level.
`timescale 1ns / 1ps
module tb_des_block_cipher_top
   import des_pkg::*;
();

   localparam int Rounds     = 16;
   localparam int LimitCycles = 400000;

   // Standard DES tables, bit 1 = MSB of the word.
   localparam byte unsigned InitPerm[64] = '{
      58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
      62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
      57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
   localparam byte unsigned FinalPerm[64] = '{
      40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
      38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
      36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
   localparam byte unsigned Expand[48] = '{
      32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
      16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
   localparam byte unsigned PPerm[32] = '{
      16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
   localparam byte unsigned SubBox[8][64] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [119:0] req_tdata;   // action, key_index, round_key_value, data_block
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;   // result_block

   // testbench copy of the key store
   logic [47:0] key_copy[16];
   logic [63:0] cipher_queue[$];
   int          errors;
   int          cycle_count;
   int          blocks_sent;
   int          loads_sent;
   int          results_seen;

   des_block_cipher_top #(.ROUND_COUNT(Rounds)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));

   always begin
      clock = 1'b0; #6;
      clock = 1'b1; #6;
   end

   // ---- predictor ----------------------------------------------------
   function automatic logic [31:0] feistel_f(logic [31:0] r, logic [47:0] k);
      logic [47:0] x;
      logic [31:0] s, p;
      logic [5:0]  six;
      for (int i = 0; i < 48; i++) x[47-i] = r[32-Expand[i]];
      x = x ^ k;
      for (int i = 0; i < 8; i++) begin
         six = x[47-6*i -: 6];
         s[31-4*i -: 4] = SubBox[i][{six[5], six[0]} * 16 + six[4:1]];
      end
      for (int i = 0; i < 32; i++) p[31-i] = s[32-PPerm[i]];
      return p;
   endfunction

   function automatic logic [63:0] des_crypt(logic [63:0] blk, bit inverse);
      logic [63:0] t, o;
      logic [31:0] l, r, nr;
      for (int i = 0; i < 64; i++) t[63-i] = blk[64-InitPerm[i]];
      l = t[63:32];
      r = t[31:0];
      for (int rnd = 0; rnd < Rounds; rnd++) begin
         nr = l ^ feistel_f(r, key_copy[inverse ? Rounds-1-rnd : rnd]);
         l  = r;
         r  = nr;
      end
      t = {r, l};
      for (int i = 0; i < 64; i++) o[63-i] = t[64-FinalPerm[i]];
      return o;
   endfunction

   // ---- sender: one beat, random gap before it -------------------------
   task automatic send_beat(action_type act, logic [3:0] idx, logic [47:0] key,
                            logic [63:0] blk);
      int gap;
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;   // back-to-back runs
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, blk, key, idx, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // accepted at this edge: update the prediction
      case (act)
         ACT_LOAD: begin
            key_copy[idx] = key;
            loads_sent++;
         end
         ACT_ENCRYPT: begin
            cipher_queue.push_back(des_crypt(blk, 1'b0));
            blocks_sent++;
         end
         ACT_DECRYPT: begin
            cipher_queue.push_back(des_crypt(blk, 1'b1));
            blocks_sent++;
         end
         default: ;   // unused action: ignored by the block
      endcase
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [47:0] rand48();
      return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
   endfunction

   // ---- result checker and receiver stalls ---------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (cipher_queue.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual %h",
                     $time, rsp_tdata);
            errors++;
         end else begin
            logic [63:0] exp_blk;
            exp_blk = cipher_queue.pop_front();
            if (rsp_tdata !== exp_blk) begin
               $display("%0t: result_block mismatch, expected %h, actual %h",
                        $time, exp_blk, rsp_tdata);
               errors++;
            end
         end
      end
   end

   // stall pattern: draw a hold time per beat, with quiet spells of no stall
   initial begin
      int hold;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         hold = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 8);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LimitCycles) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---- tests ----------------------------------------------------------
   task automatic load_all_keys(bit extreme);
      for (int i = 0; i < 16; i++)
         send_beat(ACT_LOAD, 4'(i),
                   extreme ? ((i % 2) ? 48'hFFFF_FFFF_FFFF : 48'h0) : rand48(), 64'h0);
   endtask

   // Extreme keys and blocks, both directions, unused action in between.
   task automatic test_directed();
      load_all_keys(1'b1);
      send_beat(ACT_ENCRYPT, 4'h0, 48'h0, 64'h0);
      send_beat(ACT_ENCRYPT, 4'hF, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_beat(ACT_DECRYPT, 4'h0, 48'h0, 64'h0);
      send_beat(ACT_DECRYPT, 4'h0, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF);
      // unused action with a load-like payload must leave the store alone
      send_beat(ACT_NONE, 4'h3, 48'h1234_5678_9ABC, 64'h0123_4567_89AB_CDEF);
      send_beat(ACT_ENCRYPT, 4'h0, 48'h0, 64'h0123_4567_89AB_CDEF);
      send_beat(ACT_DECRYPT, 4'h0, 48'h0, 64'h8000_0000_0000_0001);
   endtask

   // Known-answer style round trip: encrypt then decrypt the ciphertext.
   task automatic test_round_trip();
      logic [63:0] plain, ct;
      load_all_keys(1'b0);
      for (int n = 0; n < 8; n++) begin
         plain = rand64();
         ct    = des_crypt(plain, 1'b0);
         send_beat(ACT_ENCRYPT, 4'h0, 48'h0, plain);
         send_beat(ACT_DECRYPT, 4'h0, 48'h0, ct);
      end
   endtask

   // Random stream: mostly blocks, with key reloads and ignored beats mixed in.
   task automatic test_random(int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 10)
            send_beat(ACT_LOAD, 4'($urandom_range(0, 15)), rand48(), rand64());
         else if (pick < 13)
            send_beat(ACT_NONE, 4'($urandom_range(0, 15)), rand48(), rand64());
         else
            send_beat(pick < 56 ? ACT_ENCRYPT : ACT_DECRYPT,
                      4'($urandom_range(0, 15)), rand48(), rand64());
      end
   endtask

   initial begin
      int waited;
      errors       = 0;
      cycle_count  = 0;
      blocks_sent  = 0;
      loads_sent   = 0;
      results_seen = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_round_trip();
      test_random(1500);
      req_tvalid <= 1'b0;

      // drain, then wait on to catch stray beats
      waited = 0;
      while (cipher_queue.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (Rounds * 4) @(posedge clock);
      if (cipher_queue.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, cipher_queue.size());
         errors++;
      end

      $display("Covered %0d key loads and %0d encrypt/decrypt blocks, %0d results checked.",
               loads_sent, blocks_sent, results_seen);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== des_block_cipher_top.f =====
rtl/des_pkg.sv
rtl/des_block_cipher_top.sv
verif/tb_des_block_cipher_top.sv
